/* rtl/i2cbb_pkg.sv */
// Shared types and constants for the two-wire bit-bang bus master.
// Used by i2cbb_fsm and i2c_bit_bang_master; no dependencies.
package i2cbb_pkg;

	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned BIT_CNT_W = $clog2(BYTE_BITS);
	localparam logic [7:0] POLL_LIMIT_RST = 8'd50;

	typedef enum logic [2:0] {
		REQ_TICK  = 3'd0,
		REQ_START = 3'd1,
		REQ_STOP  = 3'd2,
		REQ_WRITE = 3'd3,
		REQ_READ  = 3'd4
	} req_t;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'd0,
		PH_S1    = 5'd1,
		PH_S2    = 5'd2,
		PH_S3    = 5'd3,
		PH_P1    = 5'd4,
		PH_P2    = 5'd5,
		PH_WLO   = 5'd6,
		PH_WHI   = 5'd7,
		PH_WEND  = 5'd8,
		PH_WPOLL = 5'd9,
		PH_WAHI  = 5'd10,
		PH_WALO  = 5'd11,
		PH_RLO   = 5'd12,
		PH_RHI   = 5'd13,
		PH_REND  = 5'd14,
		PH_RAHI  = 5'd15,
		PH_RALO  = 5'd16
	} phase_t;

	typedef struct packed {
		logic [2:0]           req_type;
		logic [BYTE_BITS-1:0] write_value;
		logic                 give_ack;
		logic                 sda_sample;
	} cmd_t;

	typedef struct packed {
		logic                 scl_level;
		logic                 sda_drive;
		logic                 busy_res;
		logic                 done_res;
		logic [BYTE_BITS-1:0] read_value;
		logic                 no_ack;
	} res_t;

endpackage

/* rtl/i2cbb_fsm.sv */
// Bus sequencer: phase state machine, shift/poll datapath and pin levels.
// Advances one item per step; depends on i2cbb_pkg.
module i2cbb_fsm
	import i2cbb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  cmd_t       cmd,
	input  logic [7:0] poll_limit,
	output res_t       res
);

	phase_t                phase_q, phase_d;
	logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
	logic [BYTE_BITS-1:0]  shift_q, shift_d;
	logic [BYTE_BITS-1:0]  read_hold_q, read_hold_d;
	logic [7:0]            poll_cnt_q, poll_cnt_d;
	logic                  clock_q, clock_d;
	logic                  data_q, data_d;
	logic                  ack_choice_q, ack_choice_d;
	logic                  nack_flag_q, nack_flag_d;
	logic                  is_cmd;
	logic                  msb;
	logic                  last_bit;
	logic                  ack_lvl;

	assign is_cmd   = (cmd.req_type == REQ_START) || (cmd.req_type == REQ_STOP) ||
	                  (cmd.req_type == REQ_WRITE) || (cmd.req_type == REQ_READ);
	assign msb      = shift_q[BYTE_BITS-1];
	assign last_bit = (bit_cnt_q == BIT_CNT_W'(BYTE_BITS - 1));
	assign ack_lvl  = ~ack_choice_q;

	// next state
	always_comb begin
		phase_d      = phase_q;
		bit_cnt_d    = bit_cnt_q;
		shift_d      = shift_q;
		read_hold_d  = read_hold_q;
		poll_cnt_d   = poll_cnt_q;
		clock_d      = clock_q;
		data_d       = data_q;
		ack_choice_d = ack_choice_q;
		nack_flag_d  = nack_flag_q;
		if (phase_q == PH_IDLE) begin
			if (is_cmd) begin
				bit_cnt_d   = '0;
				poll_cnt_d  = '0;
				nack_flag_d = 1'b0;
				priority if (cmd.req_type == REQ_START) begin
					phase_d = PH_S1;
				end else if (cmd.req_type == REQ_STOP) begin
					phase_d = PH_P1;
				end else if (cmd.req_type == REQ_WRITE) begin
					shift_d = cmd.write_value;
					phase_d = PH_WLO;
				end else begin
					shift_d      = '0;
					ack_choice_d = cmd.give_ack;
					phase_d      = PH_RLO;
				end
			end
		end else if (!is_cmd) begin
			unique case (phase_q)
				PH_S1: begin clock_d = 1'b1; data_d = 1'b1; phase_d = PH_S2; end
				PH_S2: begin clock_d = 1'b1; data_d = 1'b0; phase_d = PH_S3; end
				PH_S3: begin clock_d = 1'b0; data_d = 1'b0; phase_d = PH_IDLE; end
				PH_P1: begin clock_d = 1'b1; data_d = 1'b0; phase_d = PH_P2; end
				PH_P2: begin clock_d = 1'b1; data_d = 1'b1; phase_d = PH_IDLE; end
				PH_WLO: begin clock_d = 1'b0; data_d = msb; phase_d = PH_WHI; end
				PH_WHI: begin
					clock_d   = 1'b1;
					data_d    = msb;
					shift_d   = {shift_q[BYTE_BITS-2:0], 1'b0};
					bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
					phase_d   = last_bit ? PH_WEND : PH_WLO;
				end
				PH_WEND: begin clock_d = 1'b0; phase_d = PH_WPOLL; end
				PH_WPOLL: begin
					clock_d = 1'b0;
					data_d  = 1'b1;
					priority if (!cmd.sda_sample) begin
						phase_d = PH_WAHI;
					end else if (poll_cnt_q >= poll_limit) begin
						nack_flag_d = 1'b1;
						phase_d     = PH_WAHI;
					end else begin
						poll_cnt_d = poll_cnt_q + 8'd1;
					end
				end
				PH_WAHI: begin clock_d = 1'b1; data_d = 1'b1; phase_d = PH_WALO; end
				PH_WALO: begin clock_d = 1'b0; data_d = 1'b1; phase_d = PH_IDLE; end
				PH_RLO: begin clock_d = 1'b0; data_d = 1'b1; phase_d = PH_RHI; end
				PH_RHI: begin
					clock_d   = 1'b1;
					data_d    = 1'b1;
					shift_d   = {shift_q[BYTE_BITS-2:0], cmd.sda_sample};
					bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
					phase_d   = last_bit ? PH_REND : PH_RLO;
				end
				PH_REND: begin clock_d = 1'b0; data_d = ack_lvl; phase_d = PH_RAHI; end
				PH_RAHI: begin clock_d = 1'b1; data_d = ack_lvl; phase_d = PH_RALO; end
				PH_RALO: begin
					clock_d     = 1'b0;
					data_d      = ack_lvl;
					read_hold_d = shift_q;
					phase_d     = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// result
	always_comb begin
		res            = '0;
		res.scl_level  = clock_d;
		res.sda_drive  = data_d;
		res.busy_res   = (phase_d != PH_IDLE);
		res.read_value = read_hold_d;
		if (!is_cmd) begin
			unique case (phase_q)
				PH_S3, PH_P2, PH_RALO: res.done_res = 1'b1;
				PH_WALO: begin
					res.done_res = 1'b1;
					res.no_ack   = nack_flag_q;
				end
				default: res.done_res = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_cnt_q    <= '0;
			shift_q      <= '0;
			read_hold_q  <= '0;
			poll_cnt_q   <= '0;
			clock_q      <= 1'b1;
			data_q       <= 1'b1;
			ack_choice_q <= 1'b0;
			nack_flag_q  <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_cnt_q    <= bit_cnt_d;
			shift_q      <= shift_d;
			read_hold_q  <= read_hold_d;
			poll_cnt_q   <= poll_cnt_d;
			clock_q      <= clock_d;
			data_q       <= data_d;
			ack_choice_q <= ack_choice_d;
			nack_flag_q  <= nack_flag_d;
		end
	end

	a_noack_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.no_ack |-> res.done_res)
		else $error("no_ack without done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |=> phase_q == PH_IDLE)
		else $error("done but still busy");

	a_cmd_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_cmd && phase_q != PH_IDLE |=> $stable(phase_q) && $stable(clock_q))
		else $error("command while busy advanced the waveform");

	a_idle_levels: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_IDLE |=> $stable(clock_q) && $stable(data_q))
		else $error("pin levels moved while idle");

endmodule

/* rtl/i2c_bit_bang_master.sv */
// Top level of the two-wire bit-bang bus master: input stage, limit register,
// sequencer and result register. Depends on i2cbb_pkg and i2cbb_fsm.
//
//  channel  valid      stall      payload     direction
//  command  cmd_valid  cmd_stall  cmd (cmd_t) in
//  result   res_valid  res_stall  res (res_t) out
//  config   cfg_we     -          cfg_wdata   in
//
// One result per transfer; res_valid rises when the result register loads.
// One transfer per cycle unless res_stall; the sequencer steps once per item.
// A stalled result holds; the input stage still takes one more transfer.
// Reset puts both lines released, sequencer idle, acknowledge limit 50.
module i2c_bit_bang_master
	import i2cbb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  cmd_t       cmd,
	output logic       res_valid,
	input  logic       res_stall,
	output res_t       res,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	cmd_t       cmd_s1;
	logic       valid_s1;
	res_t       res_s2;
	logic       valid_s2;
	logic [7:0] poll_limit_q;
	logic       adv;
	logic       accept;
	res_t       step_res;

	assign adv       = valid_s1 && (!valid_s2 || !res_stall);
	assign cmd_stall = valid_s1 && !adv;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RST;
		end else if (cfg_we) begin
			poll_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!res_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (adv) begin
			res_s2 <= step_res;
		end
	end

	i2cbb_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.cmd        (cmd_s1),
		.poll_limit (poll_limit_q),
		.res        (step_res)
	);

	assign res_valid = valid_s2;
	assign res       = res_s2;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && valid_s2 && res_stall)
		else $error("input stalled with room downstream");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_stall && !adv |=> valid_s2 && $stable(res_s2))
		else $error("stalled result dropped or changed");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("stepped item did not reach result register");

endmodule
